>>> design/assert_macros.svh
// Assertion macros used by bus_address_register_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge, off while reset is low
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/bar_pkg.sv
// Types and constants for the bus address register
package bar_pkg;

	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SEL_W      = 4;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic [VALUE_W-1:0] HI_MASK = 16'hFF00;
	localparam logic [VALUE_W-1:0] LO_MASK = 16'h00FF;
	localparam logic [VALUE_W-1:0] VAL_ZERO = 16'h0000;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REGISTER_ID = 1'b0,
		CFG_BYTE_MODE   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [SEL_W-1:0] register_id;
		logic             byte_mode;
	} cfg_t;

	// last field in the lowest bits
	typedef struct packed {
		logic [4:0]        pad;
		logic [BYTE_W-1:0] addr_in;
		logic [BYTE_W-1:0] data_in;
		logic              op_flags;
		logic              op_index;
		logic              op_msb;
		logic              op_dec;
		logic              op_inc;
		logic              addr_strobe_n;
		logic              byte_strobe_n;
		logic [SEL_W-1:0]  select_address;
	} in_t;

	typedef struct packed {
		logic [2:0]         pad;
		logic [VALUE_W-1:0] current_value;
		logic               carry_flag;
		logic               zero_flag;
		logic               flags_update;
		logic [BYTE_W-1:0]  addr_out;
		logic               drive_addr;
		logic [BYTE_W-1:0]  data_out;
		logic               drive_data;
	} out_t;

endpackage

>>> design/bar_alu.sv
// Single-pass datapath: decodes one bus phase and computes result and next value
module bar_alu import bar_pkg::*; (
	input  in_t                item,
	input  kind_t              kind,
	input  cfg_t               cfg,
	input  logic [VALUE_W-1:0] value,
	output out_t               res,
	output logic [VALUE_W-1:0] value_next
);

	logic               hit;
	logic               bytewise;
	logic               full_rd;
	logic [VALUE_W-1:0] dec_v;
	logic [VALUE_W-1:0] mid_v;
	logic [VALUE_W-1:0] inc_v;
	logic [VALUE_W-1:0] idx_v;
	logic [VALUE_W-1:0] din_sx;

	assign hit      = (item.select_address == cfg.register_id);
	assign bytewise = cfg.byte_mode && !item.byte_strobe_n;
	assign full_rd  = hit && !bytewise && !item.addr_strobe_n;

	assign dec_v  = value - 16'd1;
	assign mid_v  = item.op_dec ? dec_v : value;
	assign inc_v  = mid_v + 16'd1;
	assign din_sx = {{BYTE_W{item.data_in[BYTE_W-1]}}, item.data_in};
	assign idx_v  = value + din_sx;

	always_comb begin
		res = '0;
		value_next = value;
		unique case (kind)
			KIND_READ: begin
				if (hit && bytewise) begin
					res.drive_data = 1'b1;
					res.data_out   = item.op_msb ? value[VALUE_W-1:BYTE_W] : value[BYTE_W-1:0];
				end else if (full_rd) begin
					res.drive_data = 1'b1;
					res.data_out   = mid_v[BYTE_W-1:0];
					res.drive_addr = 1'b1;
					res.addr_out   = mid_v[VALUE_W-1:BYTE_W];
					value_next     = item.op_inc ? inc_v : mid_v;
					// the increment's flags override the decrement's
					if (item.op_flags && item.op_inc) begin
						res.flags_update = 1'b1;
						res.zero_flag    = (inc_v == VAL_ZERO);
						res.carry_flag   = (inc_v == VAL_ZERO);
					end else if (item.op_flags && item.op_dec) begin
						res.flags_update = 1'b1;
						res.zero_flag    = (dec_v == VAL_ZERO);
					end
				end
			end
			KIND_WRITE: begin
				if (hit && bytewise) begin
					if (item.op_index) begin
						value_next = idx_v;
					end else if (item.op_msb) begin
						value_next = (value & LO_MASK) | {item.data_in, {BYTE_W{1'b0}}};
					end else begin
						value_next = (value & HI_MASK) | {{BYTE_W{1'b0}}, item.data_in};
					end
				end else if (hit && !item.addr_strobe_n) begin
					value_next = {item.addr_in, item.data_in};
				end
			end
			default: ;
		endcase
		res.current_value = value_next;
	end

endmodule

>>> design/bus_address_register_core.sv
// Top level of the bus address register: input stage, datapath, result register
// Path from input beat to result beat: input register, then result register.
// Throughput: one bus phase per cycle while the output is not stalled; the register value
// is updated as a phase moves from the input register to the result register.
// Reset: arst_n clears the value, both config registers and all valid flags.
// No clearing pass; the block accepts beats right after reset.
module bus_address_register_core import bar_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// select_address[3:0], byte_strobe_n[4], addr_strobe_n[5], op_inc[6], op_dec[7],
	// op_msb[8], op_index[9], op_flags[10], data_in[18:11], addr_in[26:19], zero[31:27]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[0]
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// drive_data[0], data_out[8:1], drive_addr[9], addr_out[17:10], flags_update[18],
	// zero_flag[19], carry_flag[20], current_value[36:21], zero[39:37]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	`include "assert_macros.svh"

	cfg_t               cfg_q;
	in_t                item_s1;
	kind_t              kind_s1;
	logic               valid_s1;
	logic               adv;
	out_t               res;
	out_t               res_q;
	logic               res_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] value_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_REGISTER_ID: cfg_q.register_id <= cfg_data[SEL_W-1:0];
				CFG_BYTE_MODE:   cfg_q.byte_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign adv           = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= in_t'(s_axis_tdata);
			kind_s1 <= kind_t'(s_axis_tuser);
		end
	end

	bar_alu u_alu (
		.item       (item_s1),
		.kind       (kind_s1),
		.cfg        (cfg_q),
		.value      (value_q),
		.res        (res),
		.value_next (value_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				value_q <= value_next;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_q;

	`ASSERT_CLK(a_value_hold, clk, arst_n, !adv |=> $stable(value_q), "value changed without a beat")
	`ASSERT_CLK(a_value_match, clk, arst_n, adv |=> (res_q.current_value == value_q), "result value differs from register")
	`ASSERT_NEVER(a_flags_no_addr, clk, arst_n, res_valid_q && res_q.flags_update && !res_q.drive_addr, "flags reported without a full address read")
	`ASSERT_NEVER(a_carry_no_zero, clk, arst_n, res_valid_q && res_q.carry_flag && !res_q.zero_flag, "carry reported without zero")

endmodule
